// File: sv/rnar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnar_pkg
// Shared constants for the reorder and NAK/ACK receiver.
// ----------------------------------------------------------------------------
package rnar_pkg;

    // Default sizing of the reorder window and the NAK backoff cap.
    localparam int REORDER_DEPTH_DEF      = 64;
    localparam int BACKOFF_CAP_FACTOR_DEF = 16;

    // Most results one packet may cause.
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Input item codes.
    localparam logic [1:0] FUNC_PACKET    = 2'd0;
    localparam logic [1:0] FUNC_TICK      = 2'd1;
    localparam logic [1:0] FUNC_HEARTBEAT = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_DELIVER = 2'd0;
    localparam logic [1:0] KIND_NAK     = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PHASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT_PHASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK_BASE_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_PERIOD        = 3'd5;

    // Register values after reset.
    localparam logic [31:0] START_SEQUENCE_RST    = 32'd1;
    localparam logic [15:0] INITIAL_PHASE_RST     = 16'd0;
    localparam logic [15:0] NAK_BASE_INTERVAL_RST = 16'd40;
    localparam logic [15:0] SILENCE_TIMEOUT_RST   = 16'd1500;
    localparam logic [15:0] ACK_PERIOD_RST        = 16'd200;

endpackage

// File: sv/rnar_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnar_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rnar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/reorder_nak_ack_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_nak_ack_receiver_top
// Subscriber endpoint of a sequenced multicast stream: reorders packets in a
// slot RAM, delivers them in order and raises NAKs and periodic ACKs.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     start / busy              func, now_clock, phase_number,
//                                     sequence_number, group_tag, payload_handle
// result    result_strobe (1 cycle)   kind, out_phase, out_sequence,
//                                     out_payload, last_of_run
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Busy covers ST_PKT and ST_FLUSH for a dropped or buffered packet, ST_HB
// and ST_FLUSH for a heartbeat, ST_FLUSH for an unknown code and ST_TICK1 to
// ST_TICK3 and ST_FLUSH for a tick. An in-order packet takes ST_PKT and
// ST_DRAIN, then ST_DRAIN_RD and ST_DRAIN for each buffered slot drained (a
// slot RAM read, then a delivery), then ST_FLUSH. Each result waits in a
// pending register until the next result or the flush, so the last one of an
// item can be marked. A register write is taken only while idle; an item
// offered in the same cycle goes first. The depth must be a power of two,
// since a slot index is the low bits of its sequence number. Reset leaves
// all slots empty. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module reorder_nak_ack_receiver_top #(
    parameter int REORDER_DEPTH      = rnar_pkg::REORDER_DEPTH_DEF,
    parameter int BACKOFF_CAP_FACTOR = rnar_pkg::BACKOFF_CAP_FACTOR_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     func,
    input  logic [31:0]                    now_clock,
    input  logic [15:0]                    phase_number,
    input  logic [31:0]                    sequence_number,
    input  logic [31:0]                    group_tag,
    input  logic [31:0]                    payload_handle,
    output logic                           result_strobe,
    output logic [1:0]                     kind,
    output logic [15:0]                    out_phase,
    output logic [31:0]                    out_sequence,
    output logic [31:0]                    out_payload,
    output logic                           last_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rnar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    import rnar_pkg::*;

    localparam int IDXW = $clog2(REORDER_DEPTH);
    localparam logic [IDXW:0]   DEPTH_X   = (IDXW + 1)'(REORDER_DEPTH);
    localparam logic [31:0]     DEPTH_32  = 32'(REORDER_DEPTH);
    localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(REORDER_DEPTH - 1);
    localparam logic [31:0]     CAP_32    = 32'(BACKOFF_CAP_FACTOR);
    localparam logic [IDXW-1:0] START_IDX = START_SEQUENCE_RST[IDXW-1:0];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PKT,
        ST_DRAIN,
        ST_DRAIN_RD,
        ST_TICK1,
        ST_TICK2,
        ST_TICK3,
        ST_HB,
        ST_FLUSH
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [31:0] start_seq_reg;
    logic [15:0] init_phase_reg;
    logic        strict_reg;
    logic [15:0] nak_base_reg;
    logic [15:0] silence_reg;
    logic [15:0] ack_period_reg;

    // Receiver state.
    logic [31:0]        exp_seq_reg;
    logic [IDXW-1:0]    exp_idx_reg;
    logic [15:0]        cur_phase_reg;
    logic [31:0]        last_del_reg;
    logic [31:0]        gap_clock_reg;
    logic [31:0]        del_clock_reg;
    logic [31:0]        nak_int_reg;
    logic [31:0]        ack_clock_reg;
    logic [31:0]        last_group_reg;
    logic [REORDER_DEPTH-1:0] slot_valid_reg;
    logic [CNT_W-1:0]   res_cnt_reg;

    // Latched input item.
    logic [31:0] in_now_reg;
    logic [15:0] in_phase_reg;
    logic [31:0] in_seq_reg;
    logic [31:0] in_group_reg;
    logic [31:0] in_pay_reg;

    // Pending result and registered result ports.
    logic        pend_valid_reg;
    logic [1:0]  pend_kind_reg;
    logic [15:0] pend_phase_reg;
    logic [31:0] pend_seq_reg;
    logic [31:0] pend_pay_reg;
    logic        res_strobe_reg;
    logic [1:0]  res_kind_reg;
    logic [15:0] res_phase_reg;
    logic [31:0] res_seq_reg;
    logic [31:0] res_pay_reg;
    logic        res_last_reg;

    // New result produced in this cycle.
    logic        new_valid;
    logic [1:0]  new_kind;
    logic [15:0] new_phase;
    logic [31:0] new_seq;
    logic [31:0] new_pay;

    // Packet decode.
    logic            ph_lt;
    logic            ph_gt;
    logic            pkt_drop;
    logic [15:0]     phase_eff;
    logic            seq_lt;
    logic            seq_eq;
    logic [31:0]     seq_off;
    logic            in_window;
    logic [IDXW:0]   widx_sum;
    logic [IDXW-1:0] widx;
    logic            nak_on_gap;
    logic [IDXW-1:0] exp_idx_inc;
    logic [31:0]     exp_m1;

    // Tick decode.
    logic            silence_hit;
    logic            nak_due;
    logic            ack_due;
    logic [31:0]     nak_cap;

    // Slot RAM ports and drained payload.
    logic            ram_we;
    logic [31:0]     ram_rdata;
    logic            drain_go;

    // Packet classification against the current phase and window.
    always_comb
    begin
        ph_lt      = in_phase_reg < cur_phase_reg;
        ph_gt      = in_phase_reg > cur_phase_reg;
        pkt_drop   = ph_lt || (ph_gt && strict_reg);
        phase_eff  = ph_gt ? in_phase_reg : cur_phase_reg;
        seq_lt     = in_seq_reg < exp_seq_reg;
        seq_eq     = in_seq_reg == exp_seq_reg;
        seq_off    = in_seq_reg - exp_seq_reg;
        in_window  = seq_off < DEPTH_32;
        widx_sum   = {1'b0, exp_idx_reg} + {1'b0, seq_off[IDXW-1:0]};
        widx       = (widx_sum >= DEPTH_X) ? IDXW'(widx_sum - DEPTH_X)
                                           : widx_sum[IDXW-1:0];
        nak_on_gap = (gap_clock_reg == 32'd0) && (last_group_reg == in_group_reg);
        exp_idx_inc = (exp_idx_reg == LAST_IDX) ? '0 : exp_idx_reg + 1'b1;
        exp_m1     = exp_seq_reg - 32'd1;
    end

    // Timer checks.
    always_comb
    begin
        silence_hit = ((in_now_reg - del_clock_reg) > {16'd0, silence_reg})
                      && (gap_clock_reg == 32'd0);
        nak_due     = (gap_clock_reg != 32'd0)
                      && ((in_now_reg - gap_clock_reg) > nak_int_reg);
        ack_due     = (in_now_reg - ack_clock_reg) > {16'd0, ack_period_reg};
        nak_cap     = {16'd0, nak_base_reg} * CAP_32;
    end

    // Drain continues while the next slot holds an item and the limit allows.
    assign drain_go = (res_cnt_reg < CNT_W'(MAX_RESULTS)) && slot_valid_reg[exp_idx_reg];

    // Result produced in the current state.
    always_comb
    begin
        new_valid = 1'b0;
        new_kind  = KIND_DELIVER;
        new_phase = cur_phase_reg;
        new_seq   = exp_m1;
        new_pay   = 32'd0;
        case (state_reg)
            ST_PKT:
            begin
                new_phase = phase_eff;
                if (!pkt_drop && !seq_lt)
                begin
                    if (!seq_eq)
                    begin
                        new_valid = nak_on_gap;
                        new_kind  = KIND_NAK;
                    end
                    else
                    begin
                        new_valid = in_seq_reg > last_del_reg;
                        new_seq   = in_seq_reg;
                        new_pay   = in_pay_reg;
                    end
                end
            end
            ST_DRAIN_RD:
            begin
                new_valid = exp_seq_reg > last_del_reg;
                new_seq   = exp_seq_reg;
                new_pay   = ram_rdata;
            end
            ST_TICK2:
            begin
                new_valid = nak_due;
                new_kind  = KIND_NAK;
            end
            ST_TICK3:
            begin
                new_valid = ack_due;
                new_kind  = KIND_ACK;
            end
            default:
            begin
                new_valid = 1'b0;
            end
        endcase
    end

    assign ram_we = (state_reg == ST_PKT) && !pkt_drop && !seq_lt && !seq_eq && in_window;

    rnar_ram #(
        .WIDTH (32),
        .DEPTH (REORDER_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx),
        .wdata (in_pay_reg),
        .raddr (exp_idx_reg),
        .rdata (ram_rdata)
    );

    // Sequencer, state registers and registered result ports.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_seq_reg  <= START_SEQUENCE_RST;
            init_phase_reg <= INITIAL_PHASE_RST;
            strict_reg     <= 1'b0;
            nak_base_reg   <= NAK_BASE_INTERVAL_RST;
            silence_reg    <= SILENCE_TIMEOUT_RST;
            ack_period_reg <= ACK_PERIOD_RST;
            exp_seq_reg    <= START_SEQUENCE_RST;
            exp_idx_reg    <= START_IDX;
            cur_phase_reg  <= INITIAL_PHASE_RST;
            last_del_reg   <= START_SEQUENCE_RST - 32'd1;
            gap_clock_reg  <= 32'd0;
            del_clock_reg  <= 32'd0;
            nak_int_reg    <= {16'd0, NAK_BASE_INTERVAL_RST};
            ack_clock_reg  <= 32'd0;
            last_group_reg <= 32'd0;
            slot_valid_reg <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            res_strobe_reg <= 1'b0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            res_strobe_reg <= 1'b0;
            res_last_reg   <= 1'b0;

            // A new result pushes the pending one out, not marked last.
            if (new_valid)
            begin
                if (pend_valid_reg)
                begin
                    res_strobe_reg <= 1'b1;
                    res_kind_reg   <= pend_kind_reg;
                    res_phase_reg  <= pend_phase_reg;
                    res_seq_reg    <= pend_seq_reg;
                    res_pay_reg    <= pend_pay_reg;
                end
                pend_valid_reg <= 1'b1;
                pend_kind_reg  <= new_kind;
                pend_phase_reg <= new_phase;
                pend_seq_reg   <= new_seq;
                pend_pay_reg   <= new_pay;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        in_now_reg   <= now_clock;
                        in_phase_reg <= phase_number;
                        in_seq_reg   <= sequence_number;
                        in_group_reg <= group_tag;
                        in_pay_reg   <= payload_handle;
                        case (func)
                            FUNC_PACKET:    state_reg <= ST_PKT;
                            FUNC_TICK:      state_reg <= ST_TICK1;
                            FUNC_HEARTBEAT: state_reg <= ST_HB;
                            default:        state_reg <= ST_FLUSH;
                        endcase
                    end
                    else if (cfg_valid)
                    begin
                        case (cfg_index)
                            CFG_START_SEQUENCE:
                            begin
                                start_seq_reg <= cfg_data;
                                exp_seq_reg   <= cfg_data;
                                last_del_reg  <= cfg_data - 32'd1;
                                exp_idx_reg   <= cfg_data[IDXW-1:0];
                            end
                            CFG_INITIAL_PHASE:
                            begin
                                init_phase_reg <= cfg_data[15:0];
                                cur_phase_reg  <= cfg_data[15:0];
                            end
                            CFG_STRICT_PHASE:
                            begin
                                strict_reg <= cfg_data[0];
                            end
                            CFG_NAK_BASE_INTERVAL:
                            begin
                                nak_base_reg <= cfg_data[15:0];
                                nak_int_reg  <= {16'd0, cfg_data[15:0]};
                            end
                            CFG_SILENCE_TIMEOUT:
                            begin
                                silence_reg <= cfg_data[15:0];
                            end
                            CFG_ACK_PERIOD:
                            begin
                                ack_period_reg <= cfg_data[15:0];
                            end
                            default:
                            begin
                                strict_reg <= strict_reg;
                            end
                        endcase
                    end
                end

                // Phase check, then buffer out of order or deliver in order.
                ST_PKT:
                begin
                    state_reg <= ST_FLUSH;
                    if (!pkt_drop)
                    begin
                        if (ph_gt)
                        begin
                            slot_valid_reg <= '0;
                            cur_phase_reg  <= in_phase_reg;
                            nak_int_reg    <= {16'd0, nak_base_reg};
                        end
                        if (!seq_lt && !seq_eq)
                        begin
                            if (nak_on_gap)
                            begin
                                gap_clock_reg <= in_now_reg;
                                nak_int_reg   <= {16'd0, nak_base_reg};
                            end
                            if (in_window)
                            begin
                                slot_valid_reg[widx] <= 1'b1;
                            end
                        end
                        else if (seq_eq)
                        begin
                            last_group_reg              <= in_group_reg;
                            slot_valid_reg[exp_idx_reg] <= 1'b0;
                            if (in_seq_reg > last_del_reg)
                            begin
                                last_del_reg <= in_seq_reg;
                                res_cnt_reg  <= CNT_W'(1);
                            end
                            else
                            begin
                                res_cnt_reg <= '0;
                            end
                            exp_seq_reg   <= exp_seq_reg + 32'd1;
                            exp_idx_reg   <= exp_idx_inc;
                            del_clock_reg <= in_now_reg;
                            gap_clock_reg <= 32'd0;
                            state_reg     <= ST_DRAIN;
                        end
                    end
                end

                // Start the read of the next buffered slot.
                ST_DRAIN:
                begin
                    if (drain_go)
                    begin
                        slot_valid_reg[exp_idx_reg] <= 1'b0;
                        state_reg <= ST_DRAIN_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end

                // Slot data is back: deliver it and move on.
                ST_DRAIN_RD:
                begin
                    if (exp_seq_reg > last_del_reg)
                    begin
                        last_del_reg <= exp_seq_reg;
                        res_cnt_reg  <= res_cnt_reg + 1'b1;
                    end
                    exp_seq_reg <= exp_seq_reg + 32'd1;
                    exp_idx_reg <= exp_idx_inc;
                    state_reg   <= ST_DRAIN;
                end

                // Silence starts the gap process.
                ST_TICK1:
                begin
                    if (silence_hit)
                    begin
                        gap_clock_reg <= in_now_reg;
                        nak_int_reg   <= {16'd0, nak_base_reg};
                    end
                    state_reg <= ST_TICK2;
                end

                // Repeat the NAK with doubling interval.
                ST_TICK2:
                begin
                    if (nak_due)
                    begin
                        gap_clock_reg <= in_now_reg;
                        if (nak_int_reg < nak_cap)
                        begin
                            nak_int_reg <= {nak_int_reg[30:0], 1'b0};
                        end
                    end
                    state_reg <= ST_TICK3;
                end

                // Periodic acknowledgement.
                ST_TICK3:
                begin
                    if (ack_due)
                    begin
                        ack_clock_reg <= in_now_reg;
                    end
                    state_reg <= ST_FLUSH;
                end

                // Heartbeat confirms that nothing is missing.
                ST_HB:
                begin
                    if ((in_phase_reg == cur_phase_reg) && (in_seq_reg == exp_m1))
                    begin
                        del_clock_reg <= in_now_reg;
                        gap_clock_reg <= 32'd0;
                    end
                    state_reg <= ST_FLUSH;
                end

                // Send the pending result as the last one of the item.
                ST_FLUSH:
                begin
                    if (pend_valid_reg)
                    begin
                        res_strobe_reg <= 1'b1;
                        res_last_reg   <= 1'b1;
                        res_kind_reg   <= pend_kind_reg;
                        res_phase_reg  <= pend_phase_reg;
                        res_seq_reg    <= pend_seq_reg;
                        res_pay_reg    <= pend_pay_reg;
                    end
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = state_reg != ST_IDLE;
    assign cfg_ready     = (state_reg == ST_IDLE) && !start;
    assign result_strobe = res_strobe_reg;
    assign kind          = res_kind_reg;
    assign out_phase     = res_phase_reg;
    assign out_sequence  = res_seq_reg;
    assign out_payload   = res_pay_reg;
    assign last_of_run   = res_last_reg;

    // Results only come out of work on an accepted item.
    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg != ST_IDLE))
        else $error("result strobe without an item in progress");

    // Nothing follows the last result of an item in the next cycle.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_of_run) |=> !result_strobe)
        else $error("result after the last of a run");

    // The slot index stays inside the window.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, exp_idx_reg} < DEPTH_X)
        else $error("slot index out of range");

    // The drain never exceeds the result limit.
    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("drain exceeded the result limit");

endmodule

// File: verif/tb_reorder_nak_ack_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reorder_nak_ack_receiver_top
// Self-checking bench for the reorder and NAK/ACK receiver. A directed table
// covers field extremes, every function code and the corner cases. Random
// packet streams, ticks and heartbeats then run under four register
// settings and three sender idle profiles. Each result is compared with a
// behavioral copy in the bench or, for fixed rows, the row's expected result.
// ----------------------------------------------------------------------------
module tb_reorder_nak_ack_receiver_top;
    import rnar_pkg::*;

    localparam int DEPTH     = REORDER_DEPTH_DEF;
    localparam int CAP       = BACKOFF_CAP_FACTOR_DEF;
    localparam int WDOG_MAX  = 4000;
    localparam int QUIET_CYC = 20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ph;
        logic [31:0] seq;
        logic [31:0] pay;
        logic        last;
    } rx_t;

    typedef struct {
        logic [1:0]  f;
        logic [31:0] now;
        logic [15:0] ph;
        logic [31:0] seq;
        logic [31:0] grp;
        logic [31:0] pay;
        bit          fixed;
        int          fcnt;
        rx_t         fres;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           func = '0;
    logic [31:0]          now_clock = '0;
    logic [15:0]          phase_number = '0;
    logic [31:0]          sequence_number = '0;
    logic [31:0]          group_tag = '0;
    logic [31:0]          payload_handle = '0;
    logic                 result_strobe;
    logic [1:0]           kind;
    logic [15:0]          out_phase;
    logic [31:0]          out_sequence;
    logic [31:0]          out_payload;
    logic                 last_of_run;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // Typed expectation carried alongside a directed item.
    logic                 fix_en = 1'b0;
    int                   fix_cnt = 0;
    rx_t                  fix_res = '0;

    // Receiver copy: registers and state.
    logic [31:0] r_start_seq = START_SEQUENCE_RST;
    logic [15:0] r_init_phase = INITIAL_PHASE_RST;
    logic        r_strict = 1'b0;
    logic [15:0] r_nak_base = NAK_BASE_INTERVAL_RST;
    logic [15:0] r_silence = SILENCE_TIMEOUT_RST;
    logic [15:0] r_ack_per = ACK_PERIOD_RST;
    logic [31:0] m_exp = START_SEQUENCE_RST;
    logic [15:0] m_phase = INITIAL_PHASE_RST;
    logic [31:0] m_last_dlv = START_SEQUENCE_RST - 1;
    logic [31:0] m_gap = '0;
    logic [31:0] m_dlv_clk = '0;
    logic [31:0] m_nak = 32'(NAK_BASE_INTERVAL_RST);
    logic [31:0] m_ack_clk = '0;
    logic [31:0] m_group = '0;
    logic [31:0] m_slot_pay [DEPTH];
    logic        m_slot_ok [DEPTH];

    rx_t         pending_rx[$];
    int          mismatches = 0;
    int          idle_cyc = 0;
    int          idle_pct = 0;
    logic [31:0] wall = 32'd1000;

    reorder_nak_ack_receiver_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .now_clock       (now_clock),
        .phase_number    (phase_number),
        .sequence_number (sequence_number),
        .group_tag       (group_tag),
        .payload_handle  (payload_handle),
        .result_strobe   (result_strobe),
        .kind            (kind),
        .out_phase       (out_phase),
        .out_sequence    (out_sequence),
        .out_payload     (out_payload),
        .last_of_run     (last_of_run),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            m_slot_ok[i]  = 1'b0;
            m_slot_pay[i] = '0;
        end
    end

    // Works out the results of one accepted item and advances the copy.
    task automatic model_item(input logic [1:0] f, input logic [31:0] now,
                              input logic [15:0] ph, input logic [31:0] seq,
                              input logic [31:0] grp, input logic [31:0] pay);
        rx_t         got[$];
        bit          go;
        int          idx;
        logic [31:0] cap;
        go  = 1'b1;
        cap = 32'(CAP) * 32'(r_nak_base);
        if (f == FUNC_PACKET)
        begin
            // Phase filter: stale dropped, newer dropped or adopted.
            if (ph < m_phase)
                go = 1'b0;
            else if (ph > m_phase)
            begin
                if (r_strict)
                    go = 1'b0;
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                        m_slot_ok[i] = 1'b0;
                    m_phase = ph;
                    m_nak   = 32'(r_nak_base);
                end
            end
            if (go && seq < m_exp)
                go = 1'b0;
            if (go && seq != m_exp)
            begin
                // Out of order: maybe start a NAK, buffer if inside the window.
                if (m_gap == 0 && m_group == grp)
                begin
                    m_gap = now;
                    m_nak = 32'(r_nak_base);
                    got.push_back('{KIND_NAK, m_phase, m_exp - 1, 32'd0, 1'b0});
                end
                if (seq - m_exp < 32'(DEPTH))
                begin
                    idx = int'(seq % 32'(DEPTH));
                    m_slot_pay[idx] = pay;
                    m_slot_ok[idx]  = 1'b1;
                end
            end
            else if (go)
            begin
                // In order: deliver, then drain buffered successors.
                m_group = grp;
                m_slot_ok[int'(m_exp % 32'(DEPTH))] = 1'b0;
                if (seq > m_last_dlv)
                begin
                    m_last_dlv = seq;
                    got.push_back('{KIND_DELIVER, m_phase, seq, pay, 1'b0});
                end
                m_exp++;
                while (got.size() < MAX_RESULTS && m_slot_ok[int'(m_exp % 32'(DEPTH))])
                begin
                    idx = int'(m_exp % 32'(DEPTH));
                    m_slot_ok[idx] = 1'b0;
                    if (m_exp > m_last_dlv)
                    begin
                        m_last_dlv = m_exp;
                        got.push_back('{KIND_DELIVER, m_phase, m_exp, m_slot_pay[idx], 1'b0});
                    end
                    m_exp++;
                end
                m_dlv_clk = now;
                m_gap     = '0;
            end
        end
        else if (f == FUNC_TICK)
        begin
            // Silence starts a NAK process; NAKs back off up to the cap.
            if (now - m_dlv_clk > 32'(r_silence) && m_gap == 0)
            begin
                m_gap = now;
                m_nak = 32'(r_nak_base);
            end
            if (m_gap != 0 && now - m_gap > m_nak)
            begin
                got.push_back('{KIND_NAK, m_phase, m_exp - 1, 32'd0, 1'b0});
                m_gap = now;
                if (m_nak < cap)
                    m_nak = m_nak * 2;
            end
            if (now - m_ack_clk > 32'(r_ack_per))
            begin
                got.push_back('{KIND_ACK, m_phase, m_exp - 1, 32'd0, 1'b0});
                m_ack_clk = now;
            end
        end
        else if (f == FUNC_HEARTBEAT)
        begin
            if (ph == m_phase && seq == m_exp - 1)
            begin
                m_dlv_clk = now;
                m_gap     = '0;
            end
        end
        if (got.size() > 0)
            got[got.size() - 1].last = 1'b1;
        if (fix_en)
        begin
            if (fix_cnt > 0)
                pending_rx.push_back(fix_res);
        end
        else
        begin
            foreach (got[i])
                pending_rx.push_back(got[i]);
        end
    endtask

    // Register writes, accepted items and results, all seen at the clock edge.
    always @(posedge clk)
    begin
        rx_t act;
        rx_t exp_rx;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_SEQUENCE:
                    begin
                        r_start_seq = cfg_data;
                        m_exp       = cfg_data;
                        m_last_dlv  = cfg_data - 1;
                    end
                    CFG_INITIAL_PHASE:
                    begin
                        r_init_phase = cfg_data[15:0];
                        m_phase      = cfg_data[15:0];
                    end
                    CFG_STRICT_PHASE:      r_strict = cfg_data[0];
                    CFG_NAK_BASE_INTERVAL:
                    begin
                        r_nak_base = cfg_data[15:0];
                        m_nak      = 32'(cfg_data[15:0]);
                    end
                    CFG_SILENCE_TIMEOUT:   r_silence = cfg_data[15:0];
                    CFG_ACK_PERIOD:        r_ack_per = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                model_item(func, now_clock, phase_number, sequence_number,
                           group_tag, payload_handle);
            if (result_strobe)
            begin
                act = '{kind, out_phase, out_sequence, out_payload, last_of_run};
                if (pending_rx.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d ph=%h seq=%h pay=%h last=%b",
                                 act.kind, act.ph, act.seq, act.pay, act.last);
                end
                else
                begin
                    exp_rx = pending_rx.pop_front();
                    if (act !== exp_rx)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp kind=%0d ph=%h seq=%h pay=%h last=%b / %s",
                                     exp_rx.kind, exp_rx.ph, exp_rx.seq, exp_rx.pay,
                                     exp_rx.last, "got below");
                        if (mismatches <= 10)
                            $display("         got kind=%0d ph=%h seq=%h pay=%h last=%b",
                                     act.kind, act.ph, act.seq, act.pay, act.last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item, result or register write.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_MAX)
        begin
            $display("tb_reorder_nak_ack_receiver_top: FAIL");
            $finish;
        end
    end

    // Offers one item and returns in the time step of the edge that takes it.
    task automatic send_item(input logic [1:0] f, input logic [31:0] now,
                             input logic [15:0] ph, input logic [31:0] seq,
                             input logic [31:0] grp, input logic [31:0] pay,
                             input bit fen, input int fcnt, input rx_t fres);
        start           <= 1'b1;
        func            <= f;
        now_clock       <= now;
        phase_number    <= ph;
        sequence_number <= seq;
        group_tag       <= grp;
        payload_handle  <= pay;
        fix_en          <= fen;
        fix_cnt         <= fcnt;
        fix_res         <= fres;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Random sender gap according to the current idle profile.
    task automatic sender_gap();
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Lets the block drain fully before registers are touched.
    task automatic wait_quiet();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rx.size() != 0 || busy);
        repeat (QUIET_CYC) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic cfg_all(input logic [31:0] sseq, input logic [15:0] ph, input logic strict,
                           input logic [15:0] nak, input logic [15:0] sil,
                           input logic [15:0] ack);
        wait_quiet();
        cfg_write(CFG_INITIAL_PHASE, 32'(ph));
        cfg_write(CFG_STRICT_PHASE, 32'(strict));
        cfg_write(CFG_NAK_BASE_INTERVAL, 32'(nak));
        cfg_write(CFG_SILENCE_TIMEOUT, 32'(sil));
        cfg_write(CFG_ACK_PERIOD, 32'(ack));
        cfg_write(CFG_START_SEQUENCE, sseq);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly near-in-order packets, with ticks, heartbeats,
    // bursts that fill the whole window, and some noise.
    task automatic random_traffic(input int count);
        int          done;
        int          r;
        logic [1:0]  f;
        logic [15:0] ph;
        logic [31:0] seq;
        logic [31:0] grp;
        logic [31:0] base;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                wall = $urandom();
            else
                wall = wall + $urandom_range(0, 250);
            if (r < 3)
            begin
                // Window burst: successors first, then the missing head.
                base = m_exp;
                for (int k = 1; k < DEPTH; k++)
                begin
                    send_item(FUNC_PACKET, wall, m_phase, base + k, $urandom(), $urandom(),
                              1'b0, 0, '0);
                    sender_gap();
                end
                send_item(FUNC_PACKET, wall, m_phase, base, m_group, $urandom(), 1'b0, 0, '0);
                sender_gap();
                done += DEPTH;
                continue;
            end
            if (r < 72)
                f = FUNC_PACKET;
            else if (r < 89)
                f = FUNC_TICK;
            else if (r < 96)
                f = FUNC_HEARTBEAT;
            else
                f = 2'd3;
            r = $urandom_range(0, 99);
            if (r < 50)
                seq = m_exp;
            else if (r < 75)
                seq = m_exp + $urandom_range(1, 10);
            else if (r < 83)
                seq = m_exp + $urandom_range(11, 80);
            else if (r < 90)
                seq = m_exp - $urandom_range(1, 5);
            else if (r < 95)
                seq = $urandom();
            else
                seq = m_exp + DEPTH - 1;
            if (f == FUNC_HEARTBEAT && $urandom_range(0, 9) < 7)
                seq = m_exp - 1;
            r = $urandom_range(0, 99);
            if (r < 90)
                ph = m_phase;
            else if (r < 94 && m_phase != 16'hFFFF)
                ph = m_phase + 1;
            else if (r < 97 && m_phase != 16'h0000)
                ph = m_phase - 1;
            else
                ph = 16'($urandom());
            r = $urandom_range(0, 99);
            grp = (r < 60) ? m_group : (r < 80) ? 32'd0 : $urandom();
            send_item(f, wall, ph, seq, grp, $urandom(), 1'b0, 0, '0);
            sender_gap();
            if (f != 2'd3)
                done++;
        end
    endtask

    initial
    begin
        dir_row_t dir_tab[$];
        rx_t      none;
        none = '0;
        // Directed rows after reset: start sequence 1, phase 0.
        dir_tab.push_back('{FUNC_PACKET, 32'd10, 16'd0, 32'd1, 32'd0, 32'h0000_00A5, 1'b1, 1,
                            '{KIND_DELIVER, 16'd0, 32'd1, 32'h0000_00A5, 1'b1}});
        dir_tab.push_back('{FUNC_PACKET, 32'd20, 16'd0, 32'd2, 32'd0, 32'hFFFF_FFFF, 1'b1, 1,
                            '{KIND_DELIVER, 16'd0, 32'd2, 32'hFFFF_FFFF, 1'b1}});
        // Old sequence and unknown function code give nothing.
        dir_tab.push_back('{FUNC_PACKET, 32'd25, 16'd0, 32'd1, 32'd0, 32'd7, 1'b1, 0, none});
        dir_tab.push_back('{2'd3, 32'd26, 16'd0, 32'd3, 32'd0, 32'd7, 1'b1, 0, none});
        // First gap with matching group raises a NAK for the last in-order number.
        dir_tab.push_back('{FUNC_PACKET, 32'd30, 16'd0, 32'd5, 32'd0, 32'd55, 1'b1, 1,
                            '{KIND_NAK, 16'd0, 32'd2, 32'd0, 1'b1}});
        dir_tab.push_back('{FUNC_PACKET, 32'd40, 16'd0, 32'd4, 32'd7, 32'd44, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_PACKET, 32'd45, 16'd0, 32'd3, 32'd0, 32'd33, 1'b0, 0, none});
        // Too far ahead of the window.
        dir_tab.push_back('{FUNC_PACKET, 32'd50, 16'd0, 32'd200, 32'd0, 32'd1, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_PACKET, 32'd55, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0, 0,
                            none});
        dir_tab.push_back('{FUNC_TICK, 32'd100, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_TICK, 32'd300, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_HEARTBEAT, 32'd310, 16'd0, 32'd5, 32'd0, 32'd0, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_HEARTBEAT, 32'd320, 16'd0, 32'd9, 32'd0, 32'd0, 1'b0, 0, none});
        // Newer phase adopted, then a stale phase dropped.
        dir_tab.push_back('{FUNC_PACKET, 32'd330, 16'hFFFF, 32'd6, 32'd0, 32'd66, 1'b0, 0,
                            none});
        dir_tab.push_back('{FUNC_PACKET, 32'd340, 16'd0, 32'd7, 32'd0, 32'd1, 1'b1, 0, none});
        dir_tab.push_back('{FUNC_TICK, 32'hFFFF_FFFF, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0, 0,
                            none});
        dir_tab.push_back('{FUNC_PACKET, 32'd0, 16'hFFFF, 32'd6, 32'd0, 32'd1, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_PACKET, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'd0, 1'b0, 0, none});
        // Same slot written twice: the later payload is the one drained.
        dir_tab.push_back('{FUNC_PACKET, 32'd5, 16'hFFFF, 32'd9, 32'd0, 32'd1, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_PACKET, 32'd6, 16'hFFFF, 32'd9, 32'd0, 32'd2, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_PACKET, 32'd7, 16'hFFFF, 32'd7, 32'd0, 32'd70, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_PACKET, 32'd8, 16'hFFFF, 32'd8, 32'd0, 32'd80, 1'b0, 0, none});
        dir_tab.push_back('{FUNC_TICK, 32'h8000_0000, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0, 0,
                            none});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (dir_tab[i])
            send_item(dir_tab[i].f, dir_tab[i].now, dir_tab[i].ph, dir_tab[i].seq,
                      dir_tab[i].grp, dir_tab[i].pay, dir_tab[i].fixed, dir_tab[i].fcnt,
                      dir_tab[i].fres);

        // Extreme settings, sender mostly busy.
        cfg_all(32'hFFFF_FFF0, 16'hFFFF, 1'b1, 16'd1, 16'd1, 16'd1);
        idle_pct = 12;
        random_traffic(150);

        // Opposite extremes, sender mostly idle.
        cfg_all(32'd1000, 16'h1234, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_pct = 66;
        random_traffic(150);

        // Start sequence zero blocks every delivery; then a moderate setting.
        cfg_all(32'd0, 16'd0, 1'b0, 16'd40, 16'd300, 16'd200);
        random_traffic(8);
        cfg_all(32'd7, 16'd0, 1'b0, 16'd40, 16'd300, 16'd200);
        idle_pct = 0;
        random_traffic(150);

        wait_quiet();
        if (mismatches == 0 && pending_rx.size() == 0)
            $display("tb_reorder_nak_ack_receiver_top: PASS");
        else
            $display("tb_reorder_nak_ack_receiver_top: FAIL");
        $finish;
    end

endmodule
